/* hdl/dqe_pkg.sv */
// shared types, codes and sizes for the double-ended queue
// no dependencies; compiled first
package dqe_pkg;

  // store size and derived widths
  localparam int DEPTH = 16;
  localparam int IDX_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  typedef logic signed [31:0] value_t;
  typedef logic [2:0]         opcode_t;
  typedef logic [1:0]         status_t;
  typedef logic [CNT_W-1:0]   cnt_t;
  typedef logic [IDX_W-1:0]   idx_t;
  typedef logic [2:0]         cell_cmd_t;

  // operation codes
  localparam opcode_t OP_PUSH_FRONT = 3'd0;
  localparam opcode_t OP_PUSH_BACK  = 3'd1;
  localparam opcode_t OP_POP_FRONT  = 3'd2;
  localparam opcode_t OP_POP_BACK   = 3'd3;
  localparam opcode_t OP_LIST       = 3'd4;

  // result status codes
  localparam status_t ST_OK    = 2'd0;
  localparam status_t ST_EMPTY = 2'd1;
  localparam status_t ST_FULL  = 2'd2;

  // per-cycle command to every cell of the row
  localparam cell_cmd_t CELL_HOLD       = 3'd0;
  localparam cell_cmd_t CELL_PUSH_FRONT = 3'd1;
  localparam cell_cmd_t CELL_PUSH_BACK  = 3'd2;
  localparam cell_cmd_t CELL_SHIFT_LEFT = 3'd3;
  localparam cell_cmd_t CELL_ROTATE     = 3'd4;

  // control broadcast from the top level to the cells
  typedef struct packed {
    cell_cmd_t cmd;
    cnt_t      count;
    value_t    push_val;
  } cell_ctl_t;

endpackage

/* hdl/dqe_in_if.sv */
// input channel: one operation item per handshake
// depends on dqe_pkg
interface dqe_in_if;
  logic             valid;
  logic             ready;
  dqe_pkg::opcode_t opcode;
  dqe_pkg::value_t  item_value;

  modport source (output valid, output opcode, output item_value, input ready);
  modport sink   (input valid, input opcode, input item_value, output ready);
endinterface

/* hdl/dqe_out_if.sv */
// result channel: one result item per handshake
// depends on dqe_pkg
interface dqe_out_if;
  logic             valid;
  logic             ready;
  dqe_pkg::value_t  out_value;
  dqe_pkg::status_t status;
  logic             last;

  modport source (output valid, output out_value, output status, output last, input ready);
  modport sink   (input valid, input out_value, input status, input last, output ready);
endinterface

/* hdl/dqe_cell.sv */
// one storage cell of the queue row; swaps data with its neighbours
// depends on dqe_pkg
module dqe_cell (
  input  logic               clk,
  input  dqe_pkg::cell_ctl_t ctl,
  input  dqe_pkg::idx_t      cell_idx,
  input  dqe_pkg::value_t    left_val,
  input  dqe_pkg::value_t    right_val,
  input  dqe_pkg::value_t    head_val,
  output dqe_pkg::value_t    value,
  output dqe_pkg::value_t    tail_tap
);
  import dqe_pkg::*;

  value_t value_r;
  value_t value_nxt;
  cnt_t   idx_ext;
  logic   is_tail;
  logic   is_free;

  assign idx_ext = cnt_t'(cell_idx);
  assign is_tail = (idx_ext == ctl.count - cnt_t'(1));
  assign is_free = (idx_ext == ctl.count);

  // next value from the broadcast command
  always_comb begin
    value_nxt = value_r;
    case (ctl.cmd)
      CELL_HOLD:       value_nxt = value_r;
      CELL_PUSH_FRONT: value_nxt = left_val;
      CELL_PUSH_BACK:  if (is_free) value_nxt = ctl.push_val;
      CELL_SHIFT_LEFT: value_nxt = right_val;
      CELL_ROTATE:     value_nxt = is_tail ? head_val : right_val;
      default:         value_nxt = value_r;
    endcase
  end

  always_ff @(posedge clk) begin
    value_r <= value_nxt;
  end

  assign value    = value_r;
  assign tail_tap = is_tail ? value_r : '0;

endmodule

/* hdl/double_ended_queue.sv */
// top level of the double-ended queue: control, result register and cell row
// depends on dqe_pkg, dqe_in_if, dqe_out_if and dqe_cell
//
// Bounded double-ended queue of signed 32-bit values, held front to back in a
// row of DEPTH cells (cell 0 is the front). A push or a pop gives one result
// item, so these run at one item per cycle as long as the result side keeps
// taking. A listing of n entries gives n result items by rotating the live
// part of the row through cell 0; input is held during that time and the row
// ends in its original order. An empty store answers a listing with one empty
// result. Results sit in an output register, so a new item is taken in the
// same cycle the previous result leaves. Opcodes without meaning give no
// result.
module double_ended_queue (
  input logic      clk,
  input logic      rst_n,
  dqe_in_if.sink   in_ch,
  dqe_out_if.source out_ch
);
  import dqe_pkg::*;

  localparam logic S_IDLE = 1'b0;
  localparam logic S_LIST = 1'b1;

  logic      state_r, state_nxt;
  cnt_t      count_r, count_nxt;
  cnt_t      list_cnt_r, list_cnt_nxt;
  logic      out_valid_r, out_valid_nxt;
  value_t    out_value_r, out_value_nxt;
  status_t   out_status_r, out_status_nxt;
  logic      out_last_r, out_last_nxt;

  cell_ctl_t ctl;
  cell_cmd_t cmd;
  value_t    vals [DEPTH];
  value_t    taps [DEPTH];
  value_t    tail_val;
  logic      slot_free;
  logic      accept;
  logic      is_full;
  logic      is_empty;

  assign slot_free   = !out_valid_r || out_ch.ready;
  assign in_ch.ready = (state_r == S_IDLE) && slot_free;
  assign accept      = in_ch.valid && in_ch.ready;
  assign is_full     = (count_r == cnt_t'(DEPTH));
  assign is_empty    = (count_r == '0);

  // back entry picked from the cell taps
  always_comb begin
    tail_val = '0;
    for (int i = 0; i < DEPTH; i++) begin
      tail_val = tail_val | taps[i];
    end
  end

  // operation control and result forming
  always_comb begin
    state_nxt      = state_r;
    count_nxt      = count_r;
    list_cnt_nxt   = list_cnt_r;
    cmd            = CELL_HOLD;
    out_valid_nxt  = out_valid_r && !out_ch.ready;
    out_value_nxt  = out_value_r;
    out_status_nxt = out_status_r;
    out_last_nxt   = out_last_r;
    if (accept) begin
      case (in_ch.opcode)
        OP_PUSH_FRONT, OP_PUSH_BACK: begin
          out_valid_nxt = 1'b1;
          out_value_nxt = '0;
          out_last_nxt  = 1'b1;
          if (is_full) begin
            out_status_nxt = ST_FULL;
          end else begin
            out_status_nxt = ST_OK;
            count_nxt      = count_r + cnt_t'(1);
            cmd = (in_ch.opcode == OP_PUSH_FRONT) ? CELL_PUSH_FRONT : CELL_PUSH_BACK;
          end
        end
        OP_POP_FRONT, OP_POP_BACK: begin
          out_valid_nxt = 1'b1;
          out_last_nxt  = 1'b1;
          if (is_empty) begin
            out_value_nxt  = '0;
            out_status_nxt = ST_EMPTY;
          end else begin
            out_status_nxt = ST_OK;
            count_nxt      = count_r - cnt_t'(1);
            if (in_ch.opcode == OP_POP_FRONT) begin
              out_value_nxt = vals[0];
              cmd           = CELL_SHIFT_LEFT;
            end else begin
              out_value_nxt = tail_val;
            end
          end
        end
        OP_LIST: begin
          out_valid_nxt = 1'b1;
          if (is_empty) begin
            out_value_nxt  = '0;
            out_status_nxt = ST_EMPTY;
            out_last_nxt   = 1'b1;
          end else begin
            out_value_nxt  = vals[0];
            out_status_nxt = ST_OK;
            out_last_nxt   = (count_r == cnt_t'(1));
            cmd            = CELL_ROTATE;
            if (count_r != cnt_t'(1)) begin
              state_nxt    = S_LIST;
              list_cnt_nxt = cnt_t'(1);
            end
          end
        end
        default: begin
          out_valid_nxt = out_valid_r && !out_ch.ready;
        end
      endcase
    end else if (state_r == S_LIST && slot_free) begin
      // one listed entry per free output slot
      out_valid_nxt  = 1'b1;
      out_value_nxt  = vals[0];
      out_status_nxt = ST_OK;
      out_last_nxt   = (list_cnt_r == count_r - cnt_t'(1));
      cmd            = CELL_ROTATE;
      list_cnt_nxt   = list_cnt_r + cnt_t'(1);
      if (list_cnt_r == count_r - cnt_t'(1)) begin
        state_nxt = S_IDLE;
      end
    end
  end

  assign ctl.cmd      = cmd;
  assign ctl.count    = count_r;
  assign ctl.push_val = in_ch.item_value;

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      list_cnt_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      list_cnt_r  <= list_cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    out_value_r  <= out_value_nxt;
    out_status_r <= out_status_nxt;
    out_last_r   <= out_last_nxt;
  end

  // row of cells, cell 0 holds the front entry
  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    value_t left_val;
    value_t right_val;
    if (g == 0) begin : g_first
      assign left_val = in_ch.item_value;
    end else begin : g_inner_l
      assign left_val = vals[g-1];
    end
    if (g == DEPTH - 1) begin : g_last
      assign right_val = vals[0];
    end else begin : g_inner_r
      assign right_val = vals[g+1];
    end
    dqe_cell u_cell (
      .clk       (clk),
      .ctl       (ctl),
      .cell_idx  (idx_t'(g)),
      .left_val  (left_val),
      .right_val (right_val),
      .head_val  (vals[0]),
      .value     (vals[g]),
      .tail_tap  (taps[g])
    );
  end

  assign out_ch.valid     = out_valid_r;
  assign out_ch.out_value = out_value_r;
  assign out_ch.status    = out_status_r;
  assign out_ch.last      = out_last_r;

endmodule
